// File: sv/wsa_pkg.sv
// Package for the windowed sample average block.
// Field widths and parameter defaults; depends on nothing.
`default_nettype none

package wsa_pkg;

  // Word field widths
  localparam int unsigned READING_W = 16;
  localparam int unsigned AVG_W     = 15;
  localparam int unsigned CNT_W     = 6;

  // Default depth of the sample memory
  localparam int unsigned MAX_WINDOW_DEF = 32;

endpackage : wsa_pkg

`default_nettype wire

// File: sv/windowed_sample_average.sv
// Windowed sample average: moving mean over the last N non-negative readings.
// Uses wsa_pkg for widths and the default memory depth.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o / reading_i): one reading per word.
//    A negative reading, or any reading while the window is 0, is not stored.
//  - Output channel (out_valid_o / out_ready_i): one word per input word with
//    the truncated mean, the accepted flag and the fill count after the update.
//  - window_size_we_i / window_size_i: sets the window (saturated to
//    MAX_WINDOW) and clears position, count and total. Write only while idle.
// Timing:
//  - in_ready_o is high only while the sequencer is idle. A stored reading
//    passes S_READ, S_UPD, S_ADD, S_DIV and S_DONE after acceptance, a
//    rejected one S_ADD, S_DIV and S_DONE; TOTAL_W is the running total width.
//  - S_DIV runs a restoring divider, which makes one quotient bit
//    per cycle from the running total and the fill count.
//  - The finished word waits in the output register; the next reading can be
//    taken and worked on meanwhile, and the sequencer holds in its final state
//    until the output register is free.
// Reset: window 0, total, count and position cleared, no word pending. The
// sample memory is not cleared; a slot's value is only used once it has been written.
`default_nettype none

module windowed_sample_average #(
  parameter int unsigned MAX_WINDOW = wsa_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration
  input  wire logic                              window_size_we_i,
  input  wire logic [wsa_pkg::CNT_W-1:0]         window_size_i,
  // input channel
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic signed [wsa_pkg::READING_W-1:0] reading_i,
  // output channel
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [wsa_pkg::AVG_W-1:0]              average_o,
  output logic                                   accepted_o,
  output logic [wsa_pkg::CNT_W-1:0]              fill_count_o
);

  localparam int unsigned AVG_W   = wsa_pkg::AVG_W;
  localparam int unsigned CNT_W   = wsa_pkg::CNT_W;
  localparam int unsigned POS_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned TOTAL_W = AVG_W + $clog2(MAX_WINDOW + 1);
  localparam int unsigned STEP_W  = $clog2(TOTAL_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPD,
    S_ADD,
    S_DIV,
    S_DONE
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   window_q;
  logic [CNT_W-1:0]   count_q;
  logic [POS_W-1:0]   pos_q;
  logic [TOTAL_W-1:0] total_q;
  logic [AVG_W-1:0]   sample_q;
  logic               acc_q;
  logic [TOTAL_W-1:0] dvd_q;
  logic [CNT_W-1:0]   rem_q;
  logic [STEP_W-1:0]  step_q;
  logic               out_valid_q;
  logic [AVG_W-1:0]   average_q;
  logic               accepted_q;
  logic [CNT_W-1:0]   fill_q;

  // sample memory, registered read
  logic [AVG_W-1:0]   mem_q [MAX_WINDOW];
  logic [AVG_W-1:0]   rdata_q;

  logic               in_fire;
  logic               full;
  logic [CNT_W:0]     rem_sh;
  logic [CNT_W:0]     rem_diff;
  logic               rem_ge;
  logic [POS_W-1:0]   pos_next;
  logic               pos_wrap;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = (count_q >= window_q);

  // next write slot, wraps at the window
  assign pos_wrap = (int'(pos_q) + 1 >= int'(window_q));
  assign pos_next = pos_wrap ? '0 : POS_W'(int'(pos_q) + 1);

  // divider step: shift in next dividend bit, trial subtract
  assign rem_sh   = {rem_q, dvd_q[TOTAL_W-1]};
  assign rem_diff = rem_sh - {1'b0, count_q};
  assign rem_ge   = (rem_sh >= {1'b0, count_q});

  // memory port
  always_ff @(posedge clk_i) begin
    if (state_q == S_UPD && acc_q) begin
      mem_q[pos_q] <= sample_q;
    end
    if (state_q == S_READ) begin
      rdata_q <= mem_q[pos_q];
    end
  end

  // sequencer, datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      window_q    <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      total_q     <= '0;
      acc_q       <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // output handshake: a finished word loads, a taken word clears
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // window write clears the running state
      if (window_size_we_i) begin
        if (int'(window_size_i) > int'(MAX_WINDOW)) begin
          window_q <= CNT_W'(MAX_WINDOW);
        end else begin
          window_q <= window_size_i;
        end
        count_q <= '0;
        pos_q   <= '0;
        total_q <= '0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            sample_q <= reading_i[AVG_W-1:0];
            acc_q    <= !reading_i[wsa_pkg::READING_W-1] && (window_q != '0);
            if (!reading_i[wsa_pkg::READING_W-1] && (window_q != '0)) begin
              state_q <= S_READ;
            end else begin
              state_q <= S_ADD;
            end
          end
        end
        S_READ: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          // drop the oldest sample once the window is full
          if (full) begin
            total_q <= total_q - TOTAL_W'(rdata_q);
          end else begin
            count_q <= count_q + CNT_W'(1);
          end
          pos_q   <= pos_next;
          state_q <= S_ADD;
        end
        S_ADD: begin
          if (acc_q) begin
            total_q <= total_q + TOTAL_W'(sample_q);
            dvd_q   <= total_q + TOTAL_W'(sample_q);
          end else begin
            dvd_q   <= total_q;
          end
          rem_q   <= '0;
          step_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q  <= rem_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
          dvd_q  <= {dvd_q[TOTAL_W-2:0], rem_ge};
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(TOTAL_W - 1)) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            average_q   <= (count_q == '0) ? '0 : dvd_q[AVG_W-1:0];
            accepted_q  <= acc_q;
            fill_q      <= count_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign average_o    = average_q;
  assign accepted_o   = accepted_q;
  assign fill_count_o = fill_q;

`ifndef ASSERT_OFF
  // fill count never exceeds the window
  a_count_le_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= window_q)
    else $error("fill count above window");

  // ready is low in the cycle after an item is accepted
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("ready right after accept");

  // a stored reading means a non-empty window
  a_accept_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && accepted_o) |-> (fill_count_o != '0))
    else $error("accepted word with zero fill count");

  // empty window reports a zero mean
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fill_count_o == '0) |-> (average_o == '0))
    else $error("nonzero average with empty window");
`endif

endmodule : windowed_sample_average

`default_nettype wire

// File: bench/tb.sv
// Testbench for windowed_sample_average: random and directed readings across window settings.
// A scoreboard class predicts each result word. Needs wsa_pkg and the block's RTL.

module tb;

  localparam int unsigned READING_W      = wsa_pkg::READING_W;
  localparam int unsigned AVG_W          = wsa_pkg::AVG_W;
  localparam int unsigned CNT_W          = wsa_pkg::CNT_W;
  localparam int unsigned SLOTS          = wsa_pkg::MAX_WINDOW_DEF;
  localparam int unsigned SLOT_W         = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned RANDOM_ITEMS   = 2000;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned TIMEOUT_CYCLES = 2000000;

  // One result word, field by field
  typedef struct packed {
    logic [AVG_W-1:0] average;
    logic             accepted;
    logic [CNT_W-1:0] fill_count;
  } mean_word_t;

  // Tracks the window contents and queues the mean word each reading should produce
  class window_mean_board;
    logic [AVG_W-1:0] samples [SLOTS];
    logic [CNT_W-1:0] window_len;
    logic [CNT_W-1:0] next_slot;
    logic [CNT_W-1:0] held;
    logic [19:0]      total;
    mean_word_t       expected_means[$];
    int unsigned      errors;

    function new();
      window_len = '0;
      next_slot  = '0;
      held       = '0;
      total      = '0;
      errors     = 0;
    endfunction

    // register write: saturate and clear position, count and total
    function void set_window(logic [CNT_W-1:0] value);
      window_len = (value > SLOTS) ? CNT_W'(SLOTS) : value;
      next_slot  = '0;
      held       = '0;
      total      = '0;
    endfunction

    function void note_reading(logic signed [READING_W-1:0] reading);
      mean_word_t       w;
      logic [CNT_W-1:0] slot;
      w = '0;
      if (!reading[READING_W-1] && window_len != 0) begin
        slot = next_slot;
        // full window: the oldest sample drops out of the total
        if (held >= window_len) total = total - 20'(samples[slot[SLOT_W-1:0]]);
        else held = held + 1'b1;
        samples[slot[SLOT_W-1:0]] = reading[AVG_W-1:0];
        total = total + 20'(reading[AVG_W-1:0]);
        slot = slot + 1'b1;
        if (slot >= window_len) slot = '0;
        next_slot  = slot;
        w.accepted = 1'b1;
      end
      if (held != 0) w.average = AVG_W'(total / 20'(held));
      w.fill_count = held;
      expected_means.push_back(w);
    endfunction

    function void check_word(mean_word_t got);
      mean_word_t exp_w;
      if (expected_means.size() == 0) begin
        $error("result word with no reading outstanding");
        errors++;
        return;
      end
      exp_w = expected_means.pop_front();
      if (got.average !== exp_w.average) begin
        $error("average: expected %0d, got %0d", exp_w.average, got.average);
        errors++;
      end
      if (got.accepted !== exp_w.accepted) begin
        $error("accepted: expected %0d, got %0d", exp_w.accepted, got.accepted);
        errors++;
      end
      if (got.fill_count !== exp_w.fill_count) begin
        $error("fill_count: expected %0d, got %0d", exp_w.fill_count, got.fill_count);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_means.size();
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        window_size_we_i;
  logic [CNT_W-1:0]            window_size_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic signed [READING_W-1:0] reading_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [AVG_W-1:0]            average_o;
  logic                        accepted_o;
  logic [CNT_W-1:0]            fill_count_o;

  window_mean_board board;
  int unsigned      burst_left;

  windowed_sample_average uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .window_size_we_i (window_size_we_i),
    .window_size_i    (window_size_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .reading_i        (reading_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .average_o        (average_o),
    .accepted_o       (accepted_o),
    .fill_count_o     (fill_count_o)
  );

  // Clock
  always #1 clk_i = ~clk_i;

  // Output monitor: check every accepted word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_word('{average_o, accepted_o, fill_count_o});
    end
  end

  // Receiver back-pressure: stretches of always-ready, stalls, random and toggling
  initial begin
    int unsigned mode;
    int unsigned len;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      len  = (mode == 1) ? $urandom_range(1, 40) : $urandom_range(1, 80);
      repeat (len) begin
        @(negedge clk_i);
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'b0;
          2: out_ready_i <= $urandom_range(0, 1);
          default: out_ready_i <= ~out_ready_i;
        endcase
      end
    end
  end

  // Send one reading; the sender works in bursts with random gaps between them
  task automatic push_reading(input logic signed [READING_W-1:0] reading);
    int unsigned gap;
    in_valid_i <= 1'b1;
    reading_i  <= reading;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_reading(reading);
    @(negedge clk_i);
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(20, 40);
        default: gap = $urandom_range(1, 12);
      endcase
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // Hold off the sender until every expected word has arrived
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_window(input logic [CNT_W-1:0] value);
    wait_drained();
    window_size_we_i <= 1'b1;
    window_size_i    <= value;
    @(negedge clk_i);
    window_size_we_i <= 1'b0;
    board.set_window(value);
  endtask

  // 0: mixed, 1: mostly full scale, 2: tiny values with rejects
  function automatic logic signed [READING_W-1:0] pick_reading(input int unsigned mode);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) return {1'b1, AVG_W'($urandom)};
    if (sel < 10) return (sel == 8) ? 16'sh8000 : 16'shFFFF;
    case (mode)
      1: return (sel < 90) ? 16'sh7FFF : {1'b0, AVG_W'($urandom)};
      2: return READING_W'($urandom_range(0, 3));
      default: begin
        if (sel < 16) return 16'sh7FFF;
        if (sel < 20) return 16'sh0000;
        return {1'b0, AVG_W'($urandom)};
      end
    endcase
  endfunction

  // Stimulus
  initial begin
    int unsigned      items;
    int unsigned      phase_len;
    int unsigned      mode;
    logic [CNT_W-1:0] win;

    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    window_size_we_i = 1'b0;
    window_size_i    = '0;
    in_valid_i       = 1'b0;
    reading_i        = '0;
    out_ready_i      = 1'b0;
    board            = new();
    burst_left       = 1;
    items            = 0;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // window 0 after reset: nothing stored, mean reported as 0
    push_reading(16'sh0000);
    push_reading(16'sh7FFF);
    push_reading(16'shFFFF);
    push_reading(16'sh8000);
    // oversized window saturates to the memory depth
    write_window(6'd63);
    push_reading(16'sh7FFF);
    push_reading(16'sh0000);
    push_reading(16'sh0001);
    push_reading(-16'sd5);
    // single-slot window: every stored reading replaces the last
    write_window(6'd1);
    push_reading(16'sd100);
    push_reading(16'sh7FFF);
    push_reading(16'sh8000);
    push_reading(16'sh0000);
    // two slots, wrapping with truncation
    write_window(6'd2);
    push_reading(16'sd7);
    push_reading(16'sd8);
    push_reading(16'sd9);
    push_reading(16'sh7FFF);

    // random phases over window settings
    while (items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       win = '0;
        1:       win = 6'd1;
        2:       win = CNT_W'(SLOTS);
        3:       win = CNT_W'($urandom_range(SLOTS + 1, 63));
        4:       win = CNT_W'($urandom_range(2, 4));
        default: win = CNT_W'($urandom_range(1, SLOTS));
      endcase
      mode      = $urandom_range(0, 4);
      mode      = (mode > 2) ? 0 : mode;
      phase_len = (win == 0) ? $urandom_range(5, 15) : $urandom_range(10, 120);
      write_window(win);
      repeat (phase_len) begin
        push_reading(pick_reading(mode));
        items++;
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (board.errors == 0 && board.pending() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // Timeout
  initial begin
    #(TIMEOUT_CYCLES * 2);
    $display("Regression FAIL");
    $finish;
  end

endmodule
